[sv/laa_pkg.sv]
`default_nettype none

package laa_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_LEVEL1   = 2'd1,
        MODE_LEVEL2   = 2'd2,
        MODE_RECOVERY = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ACT_REPORT   = 2'd0,
        ACT_OPER_RST = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_UNUSED   = 2'd3
    } action_t;

    localparam logic [1:0] PATTERN_BLANK = 2'd0;
    localparam logic [1:0] PATTERN_ONE   = 2'd1;
    localparam logic [1:0] PATTERN_TWO   = 2'd2;

    localparam logic [1:0] LEVEL_ZERO = 2'd0;
    localparam logic [1:0] LEVEL_ONE  = 2'd1;
    localparam logic [1:0] LEVEL_TWO  = 2'd2;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_IDLE_POLL  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BEEP_ON    = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BEEP_OFF   = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BLINK_HALF = 8'd3;

    localparam logic [7:0] RST_IDLE_POLL  = 8'd50;
    localparam logic [7:0] RST_BEEP_ON    = 8'd80;
    localparam logic [7:0] RST_BEEP_OFF   = 8'd120;
    localparam logic [7:0] RST_BLINK_HALF = 8'd100;

    typedef struct packed {
        logic [7:0] idle_poll_ticks;
        logic [7:0] beep_on_ticks;
        logic [7:0] beep_off_ticks;
        logic [7:0] blink_half_ticks;
    } laa_cfg_t;

    typedef struct packed {
        logic       buzzer_on;
        logic [1:0] pattern_select;
        logic       slowdown_pulse;
        logic       recover_pulse;
        logic [1:0] alarm_level;
        logic [1:0] current_mode;
    } laa_result_t;

endpackage

`default_nettype wire

[sv/laa_report_if.sv]
`default_nettype none

interface laa_report_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] reported_level;

    modport source (output valid, output action, output reported_level, input ready);
    modport sink   (input valid, input action, input reported_level, output ready);
endinterface

`default_nettype wire

[sv/laa_result_if.sv]
`default_nettype none

interface laa_result_if;
    logic       valid;
    logic       ready;
    logic       buzzer_on;
    logic [1:0] pattern_select;
    logic       slowdown_pulse;
    logic       recover_pulse;
    logic [1:0] alarm_level;
    logic [1:0] current_mode;

    modport source (
        output valid, output buzzer_on, output pattern_select, output slowdown_pulse,
        output recover_pulse, output alarm_level, output current_mode, input ready
    );
    modport sink (
        input valid, input buzzer_on, input pattern_select, input slowdown_pulse,
        input recover_pulse, input alarm_level, input current_mode, output ready
    );
endinterface

`default_nettype wire

[sv/latched_alarm_annunciator_core.sv]
// Channel   Modport  Payload
// report    sink     action, reported_level
// result    source   buzzer_on, pattern_select, slowdown_pulse, recover_pulse,
//                    alarm_level, current_mode
// cfg_*     write    cfg_we, cfg_addr (register index), cfg_wdata
//
// One item per cycle while the result is not stalled; each item passes the input
// register, then the state update and the result register.
// A stalled result holds; the input register still takes one more transfer.
// rst_n clears the valid flags and the engine state and loads the register defaults at once.
`default_nettype none

module latched_alarm_annunciator_core
    import laa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    laa_report_if.sink                 report,
    laa_result_if.source               result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    laa_cfg_t    cfg;
    laa_result_t res_comb;
    laa_result_t res_reg;
    logic        in_valid_reg;
    logic [1:0]  in_action_reg;
    logic [7:0]  in_level_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        fire;

    assign advance      = !out_valid_reg || result.ready;
    assign fire         = in_valid_reg && advance;
    assign report.ready = !in_valid_reg || advance;

    laa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    laa_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .action         (in_action_reg),
        .reported_level (in_level_reg),
        .cfg            (cfg),
        .result         (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (report.ready)
                in_valid_reg <= report.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (report.valid && report.ready)
        begin
            in_action_reg <= report.action;
            in_level_reg  <= report.reported_level;
        end
        if (fire)
            res_reg <= res_comb;
    end

    assign result.valid          = out_valid_reg;
    assign result.buzzer_on      = res_reg.buzzer_on;
    assign result.pattern_select = res_reg.pattern_select;
    assign result.slowdown_pulse = res_reg.slowdown_pulse;
    assign result.recover_pulse  = res_reg.recover_pulse;
    assign result.alarm_level    = res_reg.alarm_level;
    assign result.current_mode   = res_reg.current_mode;

endmodule

`default_nettype wire

[sv/laa_cfg_regs.sv]
`default_nettype none

module laa_cfg_regs
    import laa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output laa_cfg_t                   cfg
);

    laa_cfg_t cfg_reg;
    laa_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_IDLE_POLL:  cfg_next.idle_poll_ticks  = cfg_wdata;
                REG_BEEP_ON:    cfg_next.beep_on_ticks    = cfg_wdata;
                REG_BEEP_OFF:   cfg_next.beep_off_ticks   = cfg_wdata;
                REG_BLINK_HALF: cfg_next.blink_half_ticks = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_poll_ticks  <= RST_IDLE_POLL;
            cfg_reg.beep_on_ticks    <= RST_BEEP_ON;
            cfg_reg.beep_off_ticks   <= RST_BEEP_OFF;
            cfg_reg.blink_half_ticks <= RST_BLINK_HALF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[sv/laa_engine.sv]
`default_nettype none

module laa_engine
    import laa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [1:0] action,
    input  wire logic [7:0] reported_level,
    input  wire laa_cfg_t   cfg,
    output laa_result_t     result
);

    mode_t      mode_reg, mode_next;
    mode_t      seen_reg, seen_next;
    logic [1:0] level_reg, level_next;
    logic       blink_reg, blink_next;
    logic       beep_reg, beep_next;
    logic [7:0] wait_reg, wait_next;
    logic       buzzer_reg, buzzer_next;
    logic [1:0] pattern_reg, pattern_next;
    logic       slow;
    logic       recov;
    logic [1:0] lv;
    logic [7:0] wait_dec;

    assign lv       = (reported_level > 8'd2) ? LEVEL_TWO : reported_level[1:0];
    assign wait_dec = (wait_reg != 8'd0) ? (wait_reg - 8'd1) : 8'd0;

    always_comb
    begin
        mode_next    = mode_reg;
        seen_next    = seen_reg;
        level_next   = level_reg;
        blink_next   = blink_reg;
        beep_next    = beep_reg;
        wait_next    = wait_reg;
        buzzer_next  = buzzer_reg;
        pattern_next = pattern_reg;
        slow         = 1'b0;
        recov        = 1'b0;
        case (action_t'(action))
            ACT_REPORT:
            begin
                if (lv == LEVEL_ZERO)
                begin
                    if (mode_reg == MODE_NORMAL)
                        level_next = LEVEL_ZERO;
                end
                else if (lv == LEVEL_ONE)
                begin
                    if (mode_reg == MODE_NORMAL || mode_reg == MODE_RECOVERY)
                    begin
                        level_next = LEVEL_ONE;
                        mode_next  = MODE_LEVEL1;
                    end
                end
                else
                begin
                    level_next = LEVEL_TWO;
                    mode_next  = MODE_LEVEL2;
                end
            end
            ACT_OPER_RST:
            begin
                level_next = LEVEL_ZERO;
                mode_next  = MODE_RECOVERY;
            end
            ACT_TICK:
            begin
                wait_next = wait_dec;
                if (wait_dec == 8'd0)
                begin
                    if (beep_reg)
                    begin
                        // finish the running beep before anything else
                        buzzer_next = 1'b0;
                        beep_next   = 1'b0;
                        wait_next   = cfg.beep_off_ticks;
                    end
                    else
                    begin
                        if (mode_reg != seen_reg)
                        begin
                            slow      = (mode_reg == MODE_LEVEL2);
                            recov     = (mode_reg == MODE_RECOVERY);
                            seen_next = mode_reg;
                        end
                        case (mode_reg)
                            MODE_NORMAL:
                            begin
                                buzzer_next  = 1'b0;
                                pattern_next = PATTERN_BLANK;
                                blink_next   = 1'b0;
                                wait_next    = cfg.idle_poll_ticks;
                            end
                            MODE_LEVEL1:
                            begin
                                pattern_next = PATTERN_BLANK;
                                buzzer_next  = 1'b1;
                                beep_next    = 1'b1;
                                wait_next    = cfg.beep_on_ticks;
                            end
                            MODE_LEVEL2:
                            begin
                                if (!blink_reg)
                                begin
                                    pattern_next = (level_reg >= LEVEL_TWO) ? PATTERN_TWO
                                                                            : PATTERN_ONE;
                                    buzzer_next  = 1'b1;
                                    blink_next   = 1'b1;
                                end
                                else
                                begin
                                    pattern_next = PATTERN_BLANK;
                                    buzzer_next  = 1'b0;
                                    blink_next   = 1'b0;
                                end
                                wait_next = cfg.blink_half_ticks;
                            end
                            default:
                            begin
                                buzzer_next  = 1'b0;
                                pattern_next = PATTERN_BLANK;
                                blink_next   = 1'b0;
                                mode_next    = MODE_NORMAL;
                                level_next   = LEVEL_ZERO;
                                wait_next    = cfg.idle_poll_ticks;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            seen_reg    <= MODE_NORMAL;
            level_reg   <= LEVEL_ZERO;
            blink_reg   <= 1'b0;
            beep_reg    <= 1'b0;
            wait_reg    <= 8'd0;
            buzzer_reg  <= 1'b0;
            pattern_reg <= PATTERN_BLANK;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            seen_reg    <= seen_next;
            level_reg   <= level_next;
            blink_reg   <= blink_next;
            beep_reg    <= beep_next;
            wait_reg    <= wait_next;
            buzzer_reg  <= buzzer_next;
            pattern_reg <= pattern_next;
        end
    end

    always_comb
    begin
        result.buzzer_on      = buzzer_next;
        result.pattern_select = pattern_next;
        result.slowdown_pulse = slow;
        result.recover_pulse  = recov;
        result.alarm_level    = level_next;
        result.current_mode   = mode_next;
    end

endmodule

`default_nettype wire
